>>> hdl/assert_macros.svh
// Assertion macros used by the field multiplier top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> hdl/fmul_pkg.sv
// Package with widths and constants of the radix 2^51 field multiplier.
package fmul_pkg;
  localparam int LimbW = 51;
  localparam int NumLimbs = 5;
  localparam int B19W = 56;
  localparam int PartW = 32;
  localparam int ColW = 112;
  localparam int CarryW = 62;
  localparam logic [4:0] FoldFactor = 5'd19;
  typedef logic [LimbW-1:0] limb_t;
  typedef logic [B19W-1:0] limb19_t;
  typedef logic [ColW-1:0] col_t;
  typedef logic [CarryW-1:0] carry_t;
endpackage

>>> hdl/fmul_lane.sv
// One lane: a 51 x 56 product built from four registered partial products.
module fmul_lane (
  input  logic            clk,
  input  fmul_pkg::limb_t   a,
  input  fmul_pkg::limb19_t b,
  output logic [106:0]    prod
);
  logic [18:0] a_hi;
  logic [23:0] b_hi;
  logic [63:0] p_ll, p_lh, p_hl;
  logic [42:0] p_hh;
  assign a_hi = a[50:32];
  assign b_hi = b[55:32];
  // First stage: partial products, each at most 32 x 32 bits.
  always_ff @(posedge clk) begin
    p_ll <= 64'(a[31:0]) * 64'(b[31:0]);
    p_lh <= 64'(a[31:0]) * 64'(b_hi);
    p_hl <= 64'(a_hi) * 64'(b[31:0]);
    p_hh <= 43'(a_hi) * 43'(b_hi);
  end
  // Second stage: align and sum the partial products.
  always_ff @(posedge clk) begin
    prod <= 107'(p_ll) + (107'(p_lh) << 32) + (107'(p_hl) << 32) + (107'(p_hh) << 64);
  end
endmodule

>>> hdl/fmul_merge.sv
// Column sums, carry chain and final fold by 19.
module fmul_merge (
  input  logic                clk,
  input  logic [106:0]        prods [25],
  output fmul_pkg::limb_t     l0,
  output logic [51:0]         l1,
  output fmul_pkg::limb_t     l2,
  output fmul_pkg::limb_t     l3,
  output fmul_pkg::limb_t     l4
);
  fmul_pkg::col_t col [5];
  fmul_pkg::col_t c [5];
  fmul_pkg::carry_t cy [6];
  fmul_pkg::limb_t lo_r [3];
  fmul_pkg::carry_t cy3_r;
  fmul_pkg::col_t col3_r, col4_r;
  logic [66:0] f0;
  // Registered column sums; lane index is column*5 + term.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) begin
      col[i] <= 112'(prods[i*5]) + 112'(prods[i*5+1]) + 112'(prods[i*5+2])
              + 112'(prods[i*5+3]) + 112'(prods[i*5+4]);
    end
  end
  // Carry chain through the five columns, split by a register:
  // columns 0 to 2 first, then columns 3 and 4 with the fold by 19.
  always_comb begin
    cy[0] = '0;
    for (int i = 0; i < 3; i++) begin
      c[i] = col[i] + 112'(cy[i]);
      cy[i+1] = 62'(c[i][111:51]);
    end
    c[3] = col3_r + 112'(cy3_r);
    cy[4] = 62'(c[3][111:51]);
    c[4] = col4_r + 112'(cy[4]);
    cy[5] = 62'(c[4][111:51]);
    f0 = 67'(lo_r[0]) + 67'(cy[5]) * 67'(fmul_pkg::FoldFactor);
  end
  // Register between the two halves of the carry chain.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lo_r[i] <= c[i][50:0];
    end
    cy3_r <= cy[3];
    col3_r <= col[3];
    col4_r <= col[4];
  end
  logic [66:0] f0_r;
  fmul_pkg::limb_t r1, r2, r3, r4;
  always_ff @(posedge clk) begin
    f0_r <= f0;
    r1 <= lo_r[1];
    r2 <= lo_r[2];
    r3 <= c[3][50:0];
    r4 <= c[4][50:0];
  end
  assign l0 = f0_r[50:0];
  assign l1 = 52'(r1) + 52'(f0_r[66:51]);
  assign l2 = r2;
  assign l3 = r3;
  assign l4 = r4;
endmodule

>>> hdl/field_mul_p25519_radix51.sv
// Top level of the pipelined field multiplier modulo 2^255-19.
// One multiplication is accepted every cycle (busy is always low); its result
// appears with done high once it has passed the input register, two lane multiplier
// stages, one column-sum stage, two carry-chain stages and the output register.
// The receiver cannot stall, so done must be taken when shown.
`include "assert_macros.svh"
module field_mul_p25519_radix51 (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [50:0] a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
  input  logic [50:0] b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
  output logic done,
  output logic [50:0] prod_limb0,
  output logic [51:0] prod_limb1,
  output logic [50:0] prod_limb2, prod_limb3, prod_limb4
);
  fmul_pkg::limb_t a [5];
  fmul_pkg::limb_t b [5];
  fmul_pkg::limb19_t b19 [5];
  logic [106:0] prods [25];
  logic [5:0] vld;
  fmul_pkg::limb_t m0, m2, m3, m4;
  logic [51:0] m1;
  assign a = '{a_limb0, a_limb1, a_limb2, a_limb3, a_limb4};
  assign b = '{b_limb0, b_limb1, b_limb2, b_limb3, b_limb4};
  assign busy = 1'b0;
  // Input register with folded copies of b.
  fmul_pkg::limb_t ar [5];
  fmul_pkg::limb_t br [5];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) begin
      ar[i] <= a[i];
      br[i] <= b[i];
      b19[i] <= 56'(b[i]) * 56'(fmul_pkg::FoldFactor);
    end
  end
  // Twenty-five product lanes, grouped by column.
  for (genvar k = 0; k < 5; k++) begin : g_col
    for (genvar j = 0; j < 5; j++) begin : g_term
      fmul_lane u_lane (
        .clk  (clk),
        .a    (ar[j]),
        .b    ((k >= j) ? 56'(br[(k - j + 5) % 5]) : b19[(k - j + 5) % 5]),
        .prod (prods[k*5+j])
      );
    end
  end
  fmul_merge u_merge (
    .clk(clk), .prods(prods), .l0(m0), .l1(m1), .l2(m2), .l3(m3), .l4(m4)
  );
  // Valid pipeline tracking each transfer through the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[4:0], start};
      done <= vld[5];
    end
  end
  always_ff @(posedge clk) begin
    prod_limb0 <= m0;
    prod_limb1 <= m1;
    prod_limb2 <= m2;
    prod_limb3 <= m3;
    prod_limb4 <= m4;
  end
  `ASSERT_IMPLIES(a_busy_low, clk, rst, 1'b1, !busy)
  `ASSERT_NEXT(a_done_follows, clk, rst, vld[5], done)
  `ASSERT_NEXT(a_no_spurious, clk, rst, !vld[5], !done)
endmodule

>>> sim/field_mul_p25519_radix51_tb.sv
// Testbench for the radix 2^51 field multiplier modulo 2^255-19: random and corner operands.
module field_mul_p25519_radix51_tb;

  typedef struct {
    fmul_pkg::limb_t l0;
    logic [51:0]     l1;
    fmul_pkg::limb_t l2;
    fmul_pkg::limb_t l3;
    fmul_pkg::limb_t l4;
  } product_t;

  // Scoreboard: computes the expected product of each transfer and checks results in order.
  class product_scoreboard;
    product_t pending[$];
    int       errors;

    function product_t multiply(fmul_pkg::limb_t a[fmul_pkg::NumLimbs],
                                fmul_pkg::limb_t b[fmul_pkg::NumLimbs]);
      logic [fmul_pkg::ColW-1:0] col[fmul_pkg::NumLimbs];
      logic [fmul_pkg::ColW-1:0] sum;
      logic [fmul_pkg::ColW-1:0] carry;
      logic [63:0]               fold;
      logic [63:0]               l1;
      fmul_pkg::limb_t           limb[fmul_pkg::NumLimbs];
      logic [fmul_pkg::ColW-1:0] bv;
      product_t                  p;
      for (int i = 0; i < fmul_pkg::NumLimbs; i++) begin
        col[i] = '0;
        for (int j = 0; j < fmul_pkg::NumLimbs; j++) begin
          // Terms that wrap past limb 4 fold back with a factor of 19.
          if (i >= j) bv = fmul_pkg::ColW'(b[i-j]);
          else bv = fmul_pkg::ColW'(b[i-j+fmul_pkg::NumLimbs])
                    * fmul_pkg::ColW'(fmul_pkg::FoldFactor);
          col[i] = col[i] + fmul_pkg::ColW'(a[j]) * bv;
        end
      end
      // Single carry chain, then fold the top carry into limb 0.
      carry = '0;
      for (int i = 0; i < fmul_pkg::NumLimbs; i++) begin
        sum = col[i] + carry;
        carry = sum >> fmul_pkg::LimbW;
        limb[i] = sum[fmul_pkg::LimbW-1:0];
      end
      fold = 64'(limb[0]) + 64'(carry) * 64'(fmul_pkg::FoldFactor);
      l1 = 64'(limb[1]) + (fold >> fmul_pkg::LimbW);
      p.l0 = fold[fmul_pkg::LimbW-1:0];
      p.l1 = l1[51:0];
      p.l2 = limb[2];
      p.l3 = limb[3];
      p.l4 = limb[4];
      return p;
    endfunction

    function void note_operands(fmul_pkg::limb_t a[fmul_pkg::NumLimbs],
                                fmul_pkg::limb_t b[fmul_pkg::NumLimbs]);
      pending.push_back(multiply(a, b));
    endfunction

    function void check_product(product_t got);
      product_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no product expected: %h %h %h %h %h", $time,
                 got.l0, got.l1, got.l2, got.l3, got.l4);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.l0 !== want.l0) begin
        $display("%0t: prod_limb0 expected %h actual %h", $time, want.l0, got.l0);
        errors++;
      end
      if (got.l1 !== want.l1) begin
        $display("%0t: prod_limb1 expected %h actual %h", $time, want.l1, got.l1);
        errors++;
      end
      if (got.l2 !== want.l2) begin
        $display("%0t: prod_limb2 expected %h actual %h", $time, want.l2, got.l2);
        errors++;
      end
      if (got.l3 !== want.l3) begin
        $display("%0t: prod_limb3 expected %h actual %h", $time, want.l3, got.l3);
        errors++;
      end
      if (got.l4 !== want.l4) begin
        $display("%0t: prod_limb4 expected %h actual %h", $time, want.l4, got.l4);
        errors++;
      end
    endfunction
  endclass

  localparam fmul_pkg::limb_t LimbMax = {fmul_pkg::LimbW{1'b1}};

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  fmul_pkg::limb_t a_limb0, a_limb1, a_limb2, a_limb3, a_limb4;
  fmul_pkg::limb_t b_limb0, b_limb1, b_limb2, b_limb3, b_limb4;
  logic            done;
  fmul_pkg::limb_t prod_limb0;
  logic [51:0]     prod_limb1;
  fmul_pkg::limb_t prod_limb2, prod_limb3, prod_limb4;

  product_scoreboard products;
  bit                idle_enable;

  field_mul_p25519_radix51 u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_limb0(a_limb0), .a_limb1(a_limb1), .a_limb2(a_limb2), .a_limb3(a_limb3),
    .a_limb4(a_limb4),
    .b_limb0(b_limb0), .b_limb1(b_limb1), .b_limb2(b_limb2), .b_limb3(b_limb3),
    .b_limb4(b_limb4),
    .done(done), .prod_limb0(prod_limb0), .prod_limb1(prod_limb1),
    .prod_limb2(prod_limb2), .prod_limb3(prod_limb3), .prod_limb4(prod_limb4)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** field_mul_p25519_radix51: FAILED **");
    $finish;
  end

  // Check each result while done is high at the rising edge.
  always @(posedge clk) begin
    product_t got;
    if (!rst && done) begin
      got.l0 = prod_limb0;
      got.l1 = prod_limb1;
      got.l2 = prod_limb2;
      got.l3 = prod_limb3;
      got.l4 = prod_limb4;
      products.check_product(got);
    end
  end

  function automatic fmul_pkg::limb_t random_limb();
    fmul_pkg::limb_t v;
    v = fmul_pkg::limb_t'({$urandom, $urandom});
    // Bias toward the edges so carries and folds run long.
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = LimbMax;
      2: v = LimbMax - fmul_pkg::limb_t'($urandom_range(0, 40));
      3: v = fmul_pkg::limb_t'($urandom_range(0, 40));
      default: ;
    endcase
    return v;
  endfunction

  // Present one multiplication and hold it until a transfer takes it.
  task automatic issue(fmul_pkg::limb_t a[fmul_pkg::NumLimbs],
                       fmul_pkg::limb_t b[fmul_pkg::NumLimbs]);
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    {a_limb0, a_limb1, a_limb2, a_limb3, a_limb4} <= {a[0], a[1], a[2], a[3], a[4]};
    {b_limb0, b_limb1, b_limb2, b_limb3, b_limb4} <= {b[0], b[1], b[2], b[3], b[4]};
    @(posedge clk);
    while (busy) @(posedge clk);
    products.note_operands(a, b);
    @(negedge clk);
  endtask

  initial begin
    fmul_pkg::limb_t a[fmul_pkg::NumLimbs];
    fmul_pkg::limb_t b[fmul_pkg::NumLimbs];
    int              wait_cycles;
    products = new();
    idle_enable = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    {a_limb0, a_limb1, a_limb2, a_limb3, a_limb4} = '0;
    {b_limb0, b_limb1, b_limb2, b_limb3, b_limb4} = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed corners: zero, one, all ones, p itself, single limbs.
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < fmul_pkg::NumLimbs; i++) begin
        case (k % 5)
          0: begin a[i] = '0; b[i] = LimbMax; end
          1: begin a[i] = LimbMax; b[i] = LimbMax; end
          2: begin
            a[i] = (i == 0) ? LimbMax - fmul_pkg::limb_t'(18) : LimbMax;
            b[i] = (i == 0) ? fmul_pkg::limb_t'(1) : '0;
          end
          3: begin
            a[i] = (i == k / 5) ? LimbMax : '0;
            b[i] = (i == 4 - k / 5) ? LimbMax : '0;
          end
          default: begin
            a[i] = (i == 0) ? fmul_pkg::limb_t'(1) : '0;
            b[i] = random_limb();
          end
        endcase
      end
      issue(a, b);
    end

    // Random part; the last stretch runs back to back.
    for (int n = 0; n < 740; n++) begin
      if (n == 600) idle_enable = 1'b0;
      for (int i = 0; i < fmul_pkg::NumLimbs; i++) begin
        a[i] = random_limb();
        b[i] = random_limb();
      end
      issue(a, b);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (products.pending.size() != 0 && wait_cycles < 100) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (products.errors == 0 && products.pending.size() == 0) begin
      $display("** field_mul_p25519_radix51: PASSED **");
    end else begin
      $display("** field_mul_p25519_radix51: FAILED **");
    end
    $finish;
  end
endmodule

>>> field_mul_p25519_radix51.f
+incdir+hdl
hdl/fmul_pkg.sv
hdl/fmul_lane.sv
hdl/fmul_merge.sv
hdl/field_mul_p25519_radix51.sv
sim/field_mul_p25519_radix51_tb.sv
